[hw/rtl/ffg_pkg.sv]
// Shared constants, codes and types of the fire effect frame generator.
package ffg_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 128;
  localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int ADDR_W     = $clog2(PIXELS);
  localparam int COL_W      = $clog2(FRAME_WIDTH);
  localparam int ROW_W      = $clog2(FRAME_HEIGHT);
  localparam int HEAT_W     = 6;
  localparam int IDX_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CHANCE_W   = 16;

  localparam logic [HEAT_W-1:0] FULL_HEAT   = HEAT_W'(36);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(PIXELS - FRAME_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(PIXELS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(FRAME_WIDTH);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0]  TOP_ROW_Y   = ROW_W'(FRAME_HEIGHT - 1);

  // Operation codes
  typedef enum logic {
    OP_STEP = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BURNING     = 2'd0,
    CFG_COOLING     = 2'd1,
    CFG_OFFSET_LOW  = 2'd2,
    CFG_OFFSET_HIGH = 2'd3
  } cfg_idx_e;

  // Decoded configuration
  typedef struct packed {
    logic                burning;
    logic [CHANCE_W-1:0] cooling_chance;
    logic [1:0]          lo_mag;  // magnitude of the lowest offset, 0..3
    logic [1:0]          hi;      // highest offset, 0..3
  } cfg_t;

  // One random draw: destination offset and cooling decision
  typedef struct packed {
    logic signed [2:0] off;
    logic              cool;
  } draw_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [HEAT_W-1:0] data;
  } wr_req_t;

endpackage

[hw/rtl/ffg_item_if.sv]
// Input channel: operation code and pixel index with valid/ready.
interface ffg_item_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [ffg_pkg::IDX_W-1:0] pixel_index;

  modport source (output valid, output op, output pixel_index, input ready);
  modport sink   (input valid, input op, input pixel_index, output ready);
endinterface

[hw/rtl/ffg_result_if.sv]
// Result channel: pixel heat and frame completion flag with valid/ready.
interface ffg_result_if;
  logic                      valid;
  logic                      ready;
  logic [ffg_pkg::HEAT_W-1:0] heat;
  logic                      frame_done;

  modport source (output valid, output heat, output frame_done, input ready);
  modport sink   (input valid, input heat, input frame_done, output ready);
endinterface

[hw/rtl/ffg_heat_ram.sv]
// Heat frame store: one write port, one read port with registered data.
module ffg_heat_ram (
  input  logic                       clk_i,
  input  ffg_pkg::wr_req_t           wr_i,
  input  ffg_pkg::rd_req_t           rd_i,
  output logic [ffg_pkg::HEAT_W-1:0] rd_data_o
);

  logic [ffg_pkg::HEAT_W-1:0] mem [ffg_pkg::PIXELS];
  logic [ffg_pkg::HEAT_W-1:0] rd_data_q;

  // Read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/ffg_rng.sv]
// xorshift32 generator; turns two draws into an offset and a cooling decision.
module ffg_rng (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                draw_i,
  input  ffg_pkg::cfg_t       cfg_i,
  output ffg_pkg::draw_t      draw_o
);

  logic [31:0] state_q, state_d;
  logic [31:0] r1, r2;
  logic [2:0]  span;
  logic [18:0] prod;
  logic [3:0]  off_wide;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // Two draws per copy
  assign r1 = xorshift(state_q);
  assign r2 = xorshift(r1);

  // offset = lo + ((r1[15:0] * span) >> 16)
  assign span     = 3'({1'b0, cfg_i.hi}) + 3'({1'b0, cfg_i.lo_mag}) + 3'd1;
  assign prod     = 19'(r1[15:0]) * 19'(span);
  assign off_wide = {1'b0, prod[18:16]} - {2'b00, cfg_i.lo_mag};

  assign draw_o.off  = off_wide[2:0];
  assign draw_o.cool = r2[15:0] < cfg_i.cooling_chance;

  assign state_d = draw_i ? r2 : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 32'd1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/ffg_ctrl.sv]
// Sequencer: clearing pass, bottom row seeding, copy pipeline, reads, result register.
module ffg_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_op_i,
  input  logic [ffg_pkg::IDX_W-1:0]  in_pixel_index_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ffg_pkg::HEAT_W-1:0] out_heat_o,
  output logic                       out_frame_done_o,
  // configuration and random draws
  input  ffg_pkg::cfg_t              cfg_i,
  input  ffg_pkg::draw_t             draw_i,
  output logic                       draw_en_o,
  // heat store
  output ffg_pkg::rd_req_t           rd_o,
  output ffg_pkg::wr_req_t           wr_o,
  input  logic [ffg_pkg::HEAT_W-1:0] rd_data_i
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SEED  = 6'b000100,
    S_COPY  = 6'b001000,
    S_RDATA = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [ffg_pkg::ADDR_W-1:0] walk_q, walk_d;
  logic [ffg_pkg::COL_W-1:0]  x_q, x_d;
  logic [ffg_pkg::ROW_W-1:0]  y_q, y_d;
  logic [ffg_pkg::ROW_W-1:0]  y_last;

  // copy stage between read issue and write back
  logic                       s1_valid_q, s1_valid_d;
  logic [ffg_pkg::ADDR_W-1:0] s1_addr_q;
  logic signed [2:0]          s1_off_q;
  logic                       s1_cool_q;

  // forwarding of a write that hits the address read in the same cycle
  logic                       fwd_hit_q;
  logic [ffg_pkg::HEAT_W-1:0] fwd_data_q;
  logic [ffg_pkg::HEAT_W-1:0] mem_data;
  logic [ffg_pkg::HEAT_W-1:0] cooled;
  logic [ffg_pkg::ADDR_W-1:0] dst_addr;

  logic                       idx_ok_q, idx_ok_d;
  logic [ffg_pkg::HEAT_W-1:0] pend_heat_q, pend_heat_d;
  logic                       pend_done_q, pend_done_d;
  logic                       out_valid_q, out_valid_d;
  logic [ffg_pkg::HEAT_W-1:0] out_heat_q, out_heat_d;
  logic                       out_done_q, out_done_d;

  logic accept;
  logic col_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // last row climbed: FRAME_HEIGHT - 1 - |offset_low|
  assign y_last  = ffg_pkg::TOP_ROW_Y - ffg_pkg::ROW_W'(cfg_i.lo_mag);
  assign col_end = (y_q == y_last);

  assign mem_data = fwd_hit_q ? fwd_data_q : rd_data_i;
  assign cooled   = (s1_cool_q && (mem_data != '0)) ? mem_data - ffg_pkg::HEAT_W'(1)
                                                    : mem_data;
  // destination always lands inside the frame for the legal geometry
  assign dst_addr = s1_addr_q - ffg_pkg::ROW_STEP + ffg_pkg::ADDR_W'(s1_off_q);

  // sequencing
  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    x_d         = x_q;
    y_d         = y_q;
    s1_valid_d  = 1'b0;
    idx_ok_d    = idx_ok_q;
    pend_heat_d = pend_heat_q;
    pend_done_d = pend_done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_heat_d  = out_heat_q;
    out_done_d  = out_done_q;
    draw_en_o   = 1'b0;
    rd_o        = '0;
    wr_o        = '0;

    case (state_q)
      S_CLEAR: begin
        wr_o.en   = 1'b1;
        wr_o.addr = walk_q;
        wr_o.data = '0;
        walk_d    = walk_q + ffg_pkg::ADDR_W'(1);
        if (walk_q == ffg_pkg::LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (ffg_pkg::op_e'(in_op_i) == ffg_pkg::OP_STEP) begin
            x_d         = '0;
            pend_heat_d = '0;
            pend_done_d = 1'b1;
            state_d     = S_SEED;
          end else begin
            rd_o.en     = 1'b1;
            rd_o.addr   = ffg_pkg::ADDR_W'(in_pixel_index_i);
            idx_ok_d    = 32'(in_pixel_index_i) < 32'(ffg_pkg::PIXELS);
            pend_done_d = 1'b0;
            state_d     = S_RDATA;
          end
        end
      end
      S_SEED: begin
        wr_o.en   = 1'b1;
        wr_o.addr = ffg_pkg::BOTTOM_BASE + ffg_pkg::ADDR_W'(x_q);
        wr_o.data = cfg_i.burning ? ffg_pkg::FULL_HEAT : '0;
        x_d       = x_q + ffg_pkg::COL_W'(1);
        if (x_q == ffg_pkg::LAST_COL) begin
          x_d    = '0;
          y_d    = ffg_pkg::ROW_W'(1);
          walk_d = ffg_pkg::BOTTOM_BASE;
          state_d = (y_last == '0) ? S_DONE : S_COPY;
        end
      end
      S_COPY: begin
        // issue one copy per cycle
        rd_o.en    = 1'b1;
        rd_o.addr  = walk_q;
        draw_en_o  = 1'b1;
        s1_valid_d = 1'b1;
        if (col_end) begin
          if (x_q == ffg_pkg::LAST_COL) begin
            state_d = S_DONE;
          end else begin
            x_d    = x_q + ffg_pkg::COL_W'(1);
            y_d    = ffg_pkg::ROW_W'(1);
            walk_d = ffg_pkg::BOTTOM_BASE + ffg_pkg::ADDR_W'(x_q) + ffg_pkg::ADDR_W'(1);
          end
        end else begin
          y_d    = y_q + ffg_pkg::ROW_W'(1);
          walk_d = walk_q - ffg_pkg::ROW_STEP;
        end
      end
      S_RDATA: begin
        pend_heat_d = idx_ok_q ? mem_data : '0;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_heat_d  = pend_heat_q;
          out_done_d  = pend_done_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // write back of the copy stage
    if (s1_valid_q) begin
      wr_o.en   = 1'b1;
      wr_o.addr = dst_addr;
      wr_o.data = cooled;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      walk_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      s1_valid_q  <= s1_valid_d;
      fwd_hit_q   <= rd_o.en && wr_o.en && (rd_o.addr == wr_o.addr);
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    idx_ok_q    <= idx_ok_d;
    pend_heat_q <= pend_heat_d;
    pend_done_q <= pend_done_d;
    out_heat_q  <= out_heat_d;
    out_done_q  <= out_done_d;
    fwd_data_q  <= wr_o.data;
    s1_addr_q   <= walk_q;
    s1_off_q    <= draw_i.off;
    s1_cool_q   <= draw_i.cool;
  end

  assign out_valid_o      = out_valid_q;
  assign out_heat_o       = out_heat_q;
  assign out_frame_done_o = out_done_q;

endmodule

[hw/rtl/fire_effect_frame_generator.sv]
// Fire effect frame generator: top level with configuration registers.
//
// Input channel in_i carries an op and a pixel_index. A step op (op 0)
// seeds the bottom row, then copies every climbed pixel one row up into a
// randomly offset destination with random cooling. A read op (op 1) returns
// the heat of one pixel. Every item yields exactly one result on out_o:
// a step gives frame_done 1 and heat 0, a read gives the heat and frame_done
// 0 (heat 0 for an index outside the frame).
// One item is processed at a time. A step seeds the bottom row, then copies
// FRAME_WIDTH * (FRAME_HEIGHT - 1 - |offset_low|) pixels, one pixel copy per
// cycle with forwarding between neighboring copies; the single write port of
// the heat store sets this rate. After reset the block clears the whole heat
// store with in_i.ready low; configuration writes are taken throughout.
// The result sits in an output register; while the receiver stalls, a new
// item is still accepted and processed, and its result waits until the
// register frees.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must do so only while the block is idle: the block does not enforce it.
module fire_effect_frame_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffg_item_if.sink                       in_i,
  ffg_result_if.source                   out_o
);

  logic                         burning_q;
  logic [ffg_pkg::CHANCE_W-1:0] cooling_q;
  logic [2:0]                   off_low_q;
  logic [1:0]                   off_high_q;

  ffg_pkg::cfg_t            cfg;
  ffg_pkg::draw_t           draw;
  logic                     draw_en;
  ffg_pkg::rd_req_t         rd_req;
  ffg_pkg::wr_req_t         wr_req;
  logic [ffg_pkg::HEAT_W-1:0] rd_data;
  logic [2:0]               lo_neg;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burning_q  <= 1'b0;
      cooling_q  <= ffg_pkg::CHANCE_W'(13107);
      off_low_q  <= 3'd0;
      off_high_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (ffg_pkg::cfg_idx_e'(cfg_idx_i))
        ffg_pkg::CFG_BURNING:     burning_q  <= cfg_data_i[0];
        ffg_pkg::CFG_COOLING:     cooling_q  <= cfg_data_i[ffg_pkg::CHANCE_W-1:0];
        ffg_pkg::CFG_OFFSET_LOW:  off_low_q  <= cfg_data_i[2:0];
        ffg_pkg::CFG_OFFSET_HIGH: off_high_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // offset_low: positive values act as 0, minus four acts as minus three
  assign lo_neg = 3'd0 - off_low_q;
  always_comb begin
    cfg.burning        = burning_q;
    cfg.cooling_chance = cooling_q;
    cfg.hi             = off_high_q;
    if (!off_low_q[2]) begin
      cfg.lo_mag = 2'd0;
    end else if (off_low_q == 3'b100) begin
      cfg.lo_mag = 2'd3;
    end else begin
      cfg.lo_mag = lo_neg[1:0];
    end
  end

  ffg_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .draw_i (draw_en),
    .cfg_i  (cfg),
    .draw_o (draw)
  );

  ffg_heat_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_i      (rd_req),
    .rd_data_o (rd_data)
  );

  ffg_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .in_op_i          (in_i.op),
    .in_pixel_index_i (in_i.pixel_index),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_heat_o       (out_o.heat),
    .out_frame_done_o (out_o.frame_done),
    .cfg_i            (cfg),
    .draw_i           (draw),
    .draw_en_o        (draw_en),
    .rd_o             (rd_req),
    .wr_o             (wr_req),
    .rd_data_i        (rd_data)
  );

endmodule

[hw/rtl/ffg_checker.sv]
// Port-level assertions for the fire effect frame generator, bound to the top.
module ffg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ffg_pkg::HEAT_W-1:0] out_heat_i,
  input logic                       out_frame_done_i
);

  // one item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted twice in a row");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_heat_i)
                                   && $stable(out_frame_done_i))
    else $error("stalled result changed");

  // step results carry zero heat
  a_step_heat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_frame_done_i |-> out_heat_i == '0)
    else $error("step result with nonzero heat");

  // read results never exceed full heat
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_frame_done_i |-> out_heat_i <= ffg_pkg::FULL_HEAT)
    else $error("read heat above full heat");

endmodule

bind fire_effect_frame_generator ffg_checker u_ffg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_heat_i       (out_o.heat),
  .out_frame_done_i (out_o.frame_done)
);
